### design/mpst_pkg.sv
// Shared constants, command/status structs and controller state codes.
package mpst_pkg;

    localparam int LEAVES_DEFAULT = 1024;
    localparam int POS_W          = 10;
    localparam int VAL_W          = 8;
    localparam int OUT_W          = 18;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;   // write zero at the sweep address, advance it
        logic load;    // write the leaf, start the walk
        logic step;    // combine with sibling, write the parent
        logic report;  // copy the root into the result registers
    } mpst_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last; // sweep address is at the last node
        logic in_range;   // requested position is a real element
        logic at_root;    // the next parent written is the root
    } mpst_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_RESULT = 4'b1000
    } mpst_state_t;

endpackage

### design/mpst_datapath.sv
// Node memory, walk registers, node combine and result saturation.
module mpst_datapath #(
    parameter int LEAVES = mpst_pkg::LEAVES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpst_pkg::mpst_cmd_t                 cmd,
    output mpst_pkg::mpst_stat_t                stat,
    input  logic        [mpst_pkg::POS_W-1:0]   position,
    input  logic signed [mpst_pkg::VAL_W-1:0]   value,
    output logic signed [mpst_pkg::OUT_W-1:0]   min_prefix,
    output logic signed [mpst_pkg::OUT_W-1:0]   total
);

    localparam int LOG_P  = $clog2(LEAVES);
    localparam int ADDR_W = LOG_P + 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    // A node at height h spans 2^h elements of magnitude at most 2^(VAL_W-1)
    localparam int NODE_W = mpst_pkg::VAL_W + LOG_P;
    localparam int EXT_W  = (NODE_W > mpst_pkg::OUT_W) ? NODE_W : mpst_pkg::OUT_W;
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((2 ** (mpst_pkg::OUT_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(-(2 ** (mpst_pkg::OUT_W - 1)));
    localparam logic [31:0] LEAVES_U = 32'(LEAVES);

    typedef struct packed {
        logic signed [NODE_W-1:0] sum;
        logic signed [NODE_W-1:0] mn;
    } node_t;

    function automatic logic signed [mpst_pkg::OUT_W-1:0] sat_out(
        input logic signed [NODE_W-1:0] x
    );
        logic signed [EXT_W-1:0] ext;
        ext = EXT_W'(x);
        if (ext > SAT_HI) begin
            ext = SAT_HI;
        end
        else if (ext < SAT_LO) begin
            ext = SAT_LO;
        end
        return mpst_pkg::OUT_W'(ext);
    endfunction

    node_t mem [DEPTH];

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    node_t             cur_reg, cur_next;
    node_t             rd_data_reg;
    node_t             root_reg, root_next;
    logic signed [mpst_pkg::OUT_W-1:0] min_prefix_reg, min_prefix_next;
    logic signed [mpst_pkg::OUT_W-1:0] total_reg, total_next;

    logic [ADDR_W-1:0] leaf_addr;
    logic [ADDR_W-1:0] parent_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    node_t             wr_data;
    node_t             leaf_node;
    node_t             left_node;
    node_t             right_node;
    node_t             parent_node;
    logic signed [NODE_W-1:0] right_cand;

    // Address and status decode
    assign leaf_addr   = {1'b1, LOG_P'(position)};
    assign parent_addr = {1'b0, idx_reg[ADDR_W-1:1]};
    assign stat.clear_last = (clr_addr_reg == {ADDR_W{1'b1}});
    assign stat.in_range   = (32'(position) < LEAVES_U);
    assign stat.at_root    = (idx_reg[ADDR_W-1:1] == (ADDR_W-1)'(1));

    // Combine the held node with its sibling from memory
    always_comb
    begin
        leaf_node.sum = NODE_W'(value);
        leaf_node.mn  = NODE_W'(value);
        if (idx_reg[0])
        begin
            left_node  = rd_data_reg;
            right_node = cur_reg;
        end
        else
        begin
            left_node  = cur_reg;
            right_node = rd_data_reg;
        end
        right_cand      = left_node.sum + right_node.mn;
        parent_node.sum = left_node.sum + right_node.sum;
        parent_node.mn  = (left_node.mn < right_cand) ? left_node.mn : right_cand;
    end

    // Memory port selection and walk register updates
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        min_prefix_next = min_prefix_reg;
        total_next      = total_reg;
        wr_en           = 1'b0;
        wr_addr         = clr_addr_reg;
        wr_data         = '0;
        rd_addr         = parent_addr ^ ADDR_W'(1);
        priority if (cmd.clear)
        begin
            wr_en         = 1'b1;
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end
        else if (cmd.load)
        begin
            wr_en    = 1'b1;
            wr_addr  = leaf_addr;
            wr_data  = leaf_node;
            rd_addr  = leaf_addr ^ ADDR_W'(1);
            idx_next = leaf_addr;
            cur_next = leaf_node;
        end
        else if (cmd.step)
        begin
            wr_en    = 1'b1;
            wr_addr  = parent_addr;
            wr_data  = parent_node;
            idx_next = parent_addr;
            cur_next = parent_node;
            if (stat.at_root)
            begin
                root_next       = parent_node;
                min_prefix_next = sat_out(parent_node.mn);
                total_next      = sat_out(parent_node.sum);
            end
        end
        else if (cmd.report)
        begin
            min_prefix_next = sat_out(root_reg.mn);
            total_next      = sat_out(root_reg.sum);
        end
    end

    // Node memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            idx_reg      <= '0;
            root_reg     <= '0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            idx_reg      <= idx_next;
            root_reg     <= root_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        min_prefix_reg <= min_prefix_next;
        total_reg      <= total_next;
    end

    assign min_prefix = min_prefix_reg;
    assign total      = total_reg;

    // A walk step never starts from the root itself
    a_step_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (idx_reg[ADDR_W-1:1] != '0))
        else $error("walk step issued with no parent left");

endmodule

### design/mpst_ctrl.sv
// Controller: clearing sweep, transfer acceptance, level walk, result strobe.
module mpst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output mpst_pkg::mpst_cmd_t  cmd,
    input  mpst_pkg::mpst_stat_t stat
);

    mpst_pkg::mpst_state_t state_reg, state_next;
    logic                  accept;

    assign accept = start && (state_reg == mpst_pkg::ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            mpst_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = mpst_pkg::ST_IDLE;
                end
            end
            mpst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat.in_range)
                    begin
                        cmd.load   = 1'b1;
                        state_next = mpst_pkg::ST_WALK;
                    end
                    else
                    begin
                        cmd.report = 1'b1;
                        state_next = mpst_pkg::ST_RESULT;
                    end
                end
            end
            mpst_pkg::ST_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.at_root)
                begin
                    state_next = mpst_pkg::ST_RESULT;
                end
            end
            mpst_pkg::ST_RESULT:
            begin
                state_next = mpst_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mpst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpst_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != mpst_pkg::ST_IDLE);
    assign done = (state_reg == mpst_pkg::ST_RESULT);

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.load, cmd.step, cmd.report}))
        else $error("more than one datapath command at once");

    a_load_walks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cmd.step && busy))
        else $error("leaf load not followed by a walk step");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

endmodule

### design/min_prefix_sum_segment_tree.sv
// Top level: minimum prefix sum segment tree with single-element updates.
//
//  Channel   Handshake           Payload
//  -------   -----------------   ------------------------------------------
//  input     start & !busy       position[9:0], value[7:0] signed
//  result    done (1 cycle)      min_prefix[17:0] signed, total[17:0] signed
//
// After reset a clearing pass writes zero to all 2*P nodes (P = LEAVES rounded
// up to a power of two), one node a cycle, with busy high. An in-range write
// goes from transfer to done through a leaf write, one read-modify-write of
// the node memory per level on the single write port, and the result cycle.
// An out-of-range position reports the held root. Results cannot be stalled;
// done lasts one cycle and busy stays high through it.
module min_prefix_sum_segment_tree #(
    parameter int LEAVES = mpst_pkg::LEAVES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [mpst_pkg::POS_W-1:0]   position,
    input  logic signed [mpst_pkg::VAL_W-1:0]   value,
    output logic                                done,
    output logic signed [mpst_pkg::OUT_W-1:0]   min_prefix,
    output logic signed [mpst_pkg::OUT_W-1:0]   total
);

    mpst_pkg::mpst_cmd_t  cmd;
    mpst_pkg::mpst_stat_t stat;

    mpst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    mpst_datapath #(
        .LEAVES (LEAVES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .position   (position),
        .value      (value),
        .min_prefix (min_prefix),
        .total      (total)
    );

endmodule

### bench/min_prefix_sum_segment_tree_tb.sv
// Testbench for the minimum prefix sum segment tree: directed table, then random writes.
`timescale 1ns / 1ps

module min_prefix_sum_segment_tree_tb;

    localparam int POS_W        = mpst_pkg::POS_W;
    localparam int VAL_W        = mpst_pkg::VAL_W;
    localparam int OUT_W        = mpst_pkg::OUT_W;
    localparam int TREE_LEAVES  = mpst_pkg::LEAVES_DEFAULT;
    localparam int TREE_PAD     = 1 << $clog2(TREE_LEAVES);
    localparam int RANDOM_ITEMS = 1930;
    localparam int CALM_TAIL    = 200;
    localparam int OUT_HI       = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_LO       = -(1 << (OUT_W - 1));

    typedef struct {
        logic signed [OUT_W-1:0] min_prefix;
        logic signed [OUT_W-1:0] total;
    } root_t;

    typedef struct {
        logic        [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] val;
        bit                      typed;
        logic signed [OUT_W-1:0] min_prefix;
        logic signed [OUT_W-1:0] total;
    } write_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic        [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
    logic                    done;
    logic signed [OUT_W-1:0] min_prefix;
    logic signed [OUT_W-1:0] total;

    // Mirror of the tree: range sums and minimum prefix sums per node
    int    seg_sum [2*TREE_PAD];
    int    seg_min [2*TREE_PAD];
    root_t root_q[$];

    int errors     = 0;
    int n_writes   = 0;
    int n_results  = 0;
    int lowest_min = 0;
    int highest_min = 0;

    min_prefix_sum_segment_tree #(
        .LEAVES(TREE_LEAVES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .position  (position),
        .value     (value),
        .done      (done),
        .min_prefix(min_prefix),
        .total     (total)
    );

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Clip a root value to the result width
    function automatic logic signed [OUT_W-1:0] clip_out(input int x);
        if (x > OUT_HI)
        begin
            return OUT_W'(OUT_HI);
        end
        if (x < OUT_LO)
        begin
            return OUT_W'(OUT_LO);
        end
        return OUT_W'(x);
    endfunction

    // Write one element (if in range), refresh its path to the root, return the root
    function automatic root_t update_tree(input logic [POS_W-1:0] pos,
                                          input logic signed [VAL_W-1:0] val);
        int    node;
        int    kid;
        int    via_right;
        root_t root;
        if (pos < TREE_LEAVES)
        begin
            node          = TREE_PAD + pos;
            seg_sum[node] = val;
            seg_min[node] = val;
            node          = node >> 1;
            while (node >= 1)
            begin
                kid           = 2 * node;
                seg_sum[node] = seg_sum[kid] + seg_sum[kid+1];
                via_right     = seg_sum[kid] + seg_min[kid+1];
                seg_min[node] = (seg_min[kid] < via_right) ? seg_min[kid] : via_right;
                node          = node >> 1;
            end
        end
        root.min_prefix = clip_out(seg_min[1]);
        root.total      = clip_out(seg_sum[1]);
        return root;
    endfunction

    // Drive one write and hold it until the block takes the transfer
    task automatic send_write(input write_row_t row);
        root_t predicted;
        @(negedge clk);
        start    <= 1'b1;
        position <= row.pos;
        value    <= row.val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predicted = update_tree(row.pos, row.val);
        if (row.typed)
        begin
            predicted.min_prefix = row.min_prefix;
            predicted.total      = row.total;
        end
        root_q.push_back(predicted);
        n_writes++;
    endtask

    // Drop start for a number of cycles
    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Check each result transfer against the oldest expected root
    always @(posedge clk)
    begin
        root_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (min_prefix < lowest_min)
            begin
                lowest_min = min_prefix;
            end
            if (min_prefix > highest_min)
            begin
                highest_min = min_prefix;
            end
            if (root_q.size() == 0)
            begin
                $error("unexpected result: min_prefix %0d, total %0d", min_prefix, total);
                errors++;
            end
            else
            begin
                want = root_q.pop_front();
                if (min_prefix !== want.min_prefix)
                begin
                    $error("min_prefix mismatch: expected %0d, actual %0d",
                           want.min_prefix, min_prefix);
                    errors++;
                end
                if (total !== want.total)
                begin
                    $error("total mismatch: expected %0d, actual %0d", want.total, total);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        write_row_t directed [] = '{
            // fresh tree, then extremes at both ends
            '{10'd0,      8'sd0,    1'b1,  18'sd0,    18'sd0},
            '{10'd0,     -8'sd128,  1'b1, -18'sd128, -18'sd128},
            '{10'd1023,   8'sd127,  1'b1, -18'sd128, -18'sd1},
            '{10'd0,      8'sd127,  1'b1,  18'sd127,  18'sd254},
            '{10'd1023,  -8'sd128,  1'b1, -18'sd1,   -18'sd1},
            '{10'd0,     -8'sd128,  1'b1, -18'sd256, -18'sd256},
            '{10'd0,      8'sd0,    1'b1, -18'sd128, -18'sd128},
            '{10'd1023,   8'sd0,    1'b1,  18'sd0,    18'sd0},
            // alternating bit patterns, then the middle, quarters and near both ends
            '{10'h2AA,    8'h55,    1'b0,  18'sd0,    18'sd0},
            '{10'h155,    8'hAA,    1'b0,  18'sd0,    18'sd0},
            '{10'd512,   -8'sd1,    1'b0,  18'sd0,    18'sd0},
            '{10'd511,    8'sd1,    1'b0,  18'sd0,    18'sd0},
            '{10'd1,      8'sd127,  1'b0,  18'sd0,    18'sd0},
            '{10'd1022,  -8'sd128,  1'b0,  18'sd0,    18'sd0},
            '{10'd256,   -8'sd77,   1'b0,  18'sd0,    18'sd0},
            '{10'd768,    8'sd100,  1'b0,  18'sd0,    18'sd0},
            '{10'd2,     -8'sd128,  1'b0,  18'sd0,    18'sd0},
            '{10'd1021,   8'sd127,  1'b0,  18'sd0,    18'sd0},
            '{10'd2,      8'sd0,    1'b0,  18'sd0,    18'sd0},
            '{10'd1022,   8'sd5,    1'b0,  18'sd0,    18'sd0}
        };
        write_row_t row;
        int         mode;
        bit         calm;

        start    = 1'b0;
        position = '0;
        value    = '0;
        rst_n    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table, first rows back to back
        foreach (directed[i])
        begin
            send_write(directed[i]);
            if (i > 8 && $urandom_range(0, 2) == 0)
            begin
                hold_off($urandom_range(1, 6));
            end
        end

        // Random writes: mostly uniform, some extremes, end clusters and small non-positive values
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode      = $urandom_range(0, 9);
            row.typed = 1'b0;
            row.pos   = POS_W'($urandom_range(0, TREE_LEAVES - 1));
            row.val   = VAL_W'($urandom);
            if (mode == 6)
            begin
                row.val = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
            end
            else if (mode == 7)
            begin
                row.pos = POS_W'($urandom_range(0, 15));
            end
            else if (mode == 8)
            begin
                row.pos = POS_W'(TREE_LEAVES - 1 - $urandom_range(0, 15));
            end
            else if (mode == 9)
            begin
                row.val = -$signed(8'($urandom_range(0, 20)));
            end
            send_write(row);

            // Let all expected results drain once before carrying on
            if (n == RANDOM_ITEMS / 2)
            begin
                hold_off(1);
                while (root_q.size() != 0)
                begin
                    @(posedge clk);
                end
            end

            calm = (n >= 400 && n < 600) || (n >= RANDOM_ITEMS - CALM_TAIL);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                hold_off($urandom_range(1, 6));
            end
        end

        // Drain, then let any stray result show up
        @(negedge clk);
        start <= 1'b0;
        while (root_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);

        $display("Wrote %0d elements (%0d from the directed table), checked %0d roots,",
                 n_writes, directed.size(), n_results);
        $display("root minimum prefix sum seen from %0d to %0d", lowest_min, highest_min);
        if (errors == 0)
        begin
            $display("min_prefix_sum_segment_tree test passed");
        end
        else
        begin
            $display("min_prefix_sum_segment_tree test failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("min_prefix_sum_segment_tree test failed");
        $finish;
    end

endmodule

### files.f
design/mpst_pkg.sv
design/mpst_datapath.sv
design/mpst_ctrl.sv
design/min_prefix_sum_segment_tree.sv
bench/min_prefix_sum_segment_tree_tb.sv
